[hw/rtl/wlms_pkg.sv]
// Shared types and constants for the window local-max suppression unit.
// No dependencies; imported by window_local_max_suppression_unit.
package wlms_pkg;

   // field and register widths
   localparam int STRENGTH_W  = 16;
   localparam int ROW_W       = 12;
   localparam int PIX_COL_W   = 11;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   localparam logic [FH_W-1:0] MAX_ROWS = 13'd4096;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   // register reset values
   localparam logic [STRENGTH_W-1:0] THRESHOLD_RST    = 16'd0;
   localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 13'd480;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_VALUE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } wlms_state_type;

endpackage

[hw/rtl/window_local_max_suppression_unit.sv]
// Window local-max suppression: line store, sequencer, result register; needs wlms_pkg.
// Per result: center column read, threshold check, and above threshold a scan of the window,
// scan width <= WINDOW, one line store column read per cycle; the result is then emitted once
// the result register is free. An item that completes no window leaves the block idle.
// Bursts of up to (HALF+1)^2 results; no new item until the burst is done.
// Reset: position, sequencer, result valid and registers reset; line store not cleared.
module window_local_max_suppression_unit
   import wlms_pkg::*;
#(
   parameter int WINDOW    = 11,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   // input pixel stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [STRENGTH_W-1:0]  req_tdata,   // [15:0] strength
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [11:0] pixel_row, [22:12] pixel_col,
                                               // [38:23] kept_value, [39] zero
   output logic [0:0]             rsp_tuser,   // [0] is_keypoint
   output logic                   rsp_tlast,   // last result caused by an item
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int HALF   = (WINDOW - 1) / 2;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int WEXT_W = (WCNT_W > FW_W) ? WCNT_W : FW_W;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int OFF_W  = SLOT_W + 2;
   localparam int MROW_W = ROW_W + 3;

   localparam logic signed [OFF_W-1:0] HALF_S = OFF_W'(HALF);
   localparam logic signed [OFF_W-1:0] WIN_S  = OFF_W'(WINDOW);

   // ---------------------------------------------------------------- registers
   logic [STRENGTH_W-1:0] threshold_ff;
   logic [FW_W-1:0]       frame_width_ff;
   logic [FH_W-1:0]       frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RST;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_ff    <= csr_data;
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: ;        // unknown index ignored
         endcase
      end
   end

   // effective frame size: zero counts as one, saturate at the limits
   logic [WEXT_W-1:0] fw_ext;
   logic [WCNT_W-1:0] w_eff;
   logic [FH_W-1:0]   h_eff;

   always_comb begin
      fw_ext = WEXT_W'(frame_width_ff);
      if (frame_width_ff == '0) begin
         w_eff = WCNT_W'(1);
      end else if (fw_ext > WEXT_W'(MAX_WIDTH)) begin
         w_eff = WCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = WCNT_W'(fw_ext);
      end
      if (frame_height_ff == '0) begin
         h_eff = FH_W'(1);
      end else if (frame_height_ff > MAX_ROWS) begin
         h_eff = MAX_ROWS;
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------- line store
   // One word per column holds that column of all WINDOW row slots; a row slot
   // is row % WINDOW. Written one lane at a time, read a whole column per cycle.
   logic [WINDOW-1:0][STRENGTH_W-1:0] line_mem [MAX_WIDTH];
   logic [WINDOW-1:0][STRENGTH_W-1:0] rd_data_ff;
   logic [COL_W-1:0]                  rd_addr;
   logic                              wr_en;
   logic [COL_W-1:0]                  wr_addr;
   logic [SLOT_W-1:0]                 wr_lane;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr][wr_lane] <= req_tdata;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // ---------------------------------------------------------------- state
   wlms_state_type state_ff, state_in;

   logic [ROW_W-1:0]  row_ff, row_in;        // next input position
   logic [COL_W-1:0]  col_ff, col_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;      // row_ff % WINDOW

   logic [ROW_W-1:0]  r_ff, r_in;            // result being worked on
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [COL_W-1:0]  c_ff, c_in;
   logic [ROW_W-1:0]  rhi_ff, rhi_in;        // burst bounds
   logic [COL_W-1:0]  clo_ff, clo_in;
   logic [COL_W-1:0]  chi_ff, chi_in;

   logic [COL_W-1:0]  lft_ff, lft_in;        // scan columns of the window
   logic [COL_W-1:0]  rgt_ff, rgt_in;
   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic [WINDOW-1:0] mask_ff, mask_in;      // lanes whose rows lie in the frame
   logic [STRENGTH_W-1:0] v_ff, v_in;
   logic              greater_ff, greater_in;
   logic              pend_ff, pend_in;      // scan read data valid this cycle
   logic [STRENGTH_W-1:0] kept_ff, kept_in;

   // result register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [PIX_COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [STRENGTH_W-1:0] rsp_kept_ff, rsp_kept_in;
   logic                  rsp_key_ff, rsp_key_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- burst setup
   logic              accept;
   logic              restart;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [SLOT_W-1:0] cur_slot;
   logic              last_row, last_col, row_ge, col_ge, has_res;
   logic [ROW_W-1:0]  rlo;
   logic [COL_W-1:0]  clo;
   logic [SLOT_W-1:0] rlo_slot;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // a position outside the frame in use starts a new frame
      restart  = ({1'b0, row_ff} >= h_eff) || (WCNT_W'(col_ff) >= w_eff);
      cur_row  = restart ? '0 : row_ff;
      cur_col  = restart ? '0 : col_ff;
      cur_slot = restart ? '0 : slot_ff;
      last_row = ({1'b0, cur_row} == (h_eff - FH_W'(1)));
      last_col = (WCNT_W'(cur_col) == (w_eff - WCNT_W'(1)));
      row_ge   = (cur_row >= ROW_W'(HALF));
      col_ge   = (cur_col >= COL_W'(HALF));
      rlo      = row_ge ? (cur_row - ROW_W'(HALF)) : '0;
      clo      = col_ge ? (cur_col - COL_W'(HALF)) : '0;
      has_res  = (last_row || row_ge) && (last_col || col_ge);
      if (!row_ge) begin
         rlo_slot = '0;
      end else if (cur_slot >= SLOT_W'(HALF)) begin
         rlo_slot = cur_slot - SLOT_W'(HALF);
      end else begin
         rlo_slot = cur_slot + SLOT_W'(WINDOW - HALF);
      end
   end

   // ---------------------------------------------------------------- window limits
   logic [WCNT_W:0]   cplus;
   logic              scan_hit;
   logic              out_free;
   logic              emit_last;

   always_comb begin
      logic signed [OFF_W-1:0]  off;
      logic signed [MROW_W-1:0] mrow;
      // row lane k holds row r + off, off in [-HALF, HALF]
      for (int k = 0; k < WINDOW; k++) begin
         off = $signed({2'b00, SLOT_W'(k)}) - $signed({2'b00, rslot_ff});
         if (off > HALF_S) begin
            off = off - WIN_S;
         end
         if (off < -HALF_S) begin
            off = off + WIN_S;
         end
         mrow = $signed({3'b000, r_ff}) + MROW_W'(off);
         mask_in[k] = (off >= -HALF_S) && (off <= HALF_S) && (mrow >= 0) &&
                      (mrow < $signed({2'b00, h_eff}));
      end
      lft_in = (c_ff >= COL_W'(HALF)) ? (c_ff - COL_W'(HALF)) : '0;
      cplus  = (WCNT_W + 1)'(c_ff) + (WCNT_W + 1)'(HALF);
      rgt_in = (cplus >= {1'b0, w_eff}) ? COL_W'(w_eff - WCNT_W'(1)) : COL_W'(cplus);
   end

   always_comb begin
      scan_hit = 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
         scan_hit = scan_hit | (mask_ff[k] && (rd_data_ff[k] > v_ff));
      end
   end

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign emit_last = (r_ff == rhi_ff) && (c_ff == chi_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      slot_in     = slot_ff;
      r_in        = r_ff;
      rslot_in    = rslot_ff;
      c_in        = c_ff;
      rhi_in      = rhi_ff;
      clo_in      = clo_ff;
      chi_in      = chi_ff;
      scan_col_in = scan_col_ff;
      v_in        = v_ff;
      greater_in  = greater_ff;
      kept_in     = kept_ff;
      pend_in     = (state_ff == ST_SCAN);
      wr_en       = 1'b0;
      wr_addr     = cur_col;
      wr_lane     = cur_slot;
      rd_addr     = (state_ff == ST_SCAN) ? scan_col_ff : c_ff;

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_kept_in   = rsp_kept_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;

      if (pend_ff) begin
         greater_in = greater_ff | scan_hit;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_en = 1'b1;
               // advance raster position
               if (last_col) begin
                  col_in = '0;
                  if (last_row) begin
                     row_in  = '0;
                     slot_in = '0;
                  end else begin
                     row_in  = cur_row + ROW_W'(1);
                     slot_in = (cur_slot == SLOT_W'(WINDOW - 1)) ?
                               '0 : (cur_slot + SLOT_W'(1));
                  end
               end else begin
                  col_in  = cur_col + COL_W'(1);
                  row_in  = cur_row;
                  slot_in = cur_slot;
               end
               // burst of results completed by this item
               r_in     = rlo;
               rslot_in = rlo_slot;
               rhi_in   = last_row ? cur_row : rlo;
               c_in     = clo;
               clo_in   = clo;
               chi_in   = last_col ? cur_col : clo;
               if (has_res) begin
                  state_in = ST_CENTER;
               end
            end
         end
         ST_CENTER: begin
            // center column read issued; window limits latched
            state_in = ST_VALUE;
         end
         ST_VALUE: begin
            v_in = rd_data_ff[rslot_ff];
            if (rd_data_ff[rslot_ff] <= threshold_ff) begin
               kept_in  = rd_data_ff[rslot_ff];
               state_in = ST_EMIT;
            end else begin
               scan_col_in = lft_ff;
               greater_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_col_ff == rgt_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_col_in = scan_col_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            kept_in  = (greater_ff || scan_hit) ? '0 : v_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_row_in    = r_ff;
               rsp_col_in    = PIX_COL_W'(c_ff);
               rsp_kept_in   = kept_ff;
               rsp_key_in    = (kept_ff > threshold_ff);
               rsp_last_in   = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CENTER;
                  if (c_ff == chi_ff) begin
                     c_in     = clo_ff;
                     r_in     = r_ff + ROW_W'(1);
                     rslot_in = (rslot_ff == SLOT_W'(WINDOW - 1)) ?
                                '0 : (rslot_ff + SLOT_W'(1));
                  end else begin
                     c_in = c_ff + COL_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         slot_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         slot_ff       <= slot_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      rslot_ff    <= rslot_in;
      c_ff        <= c_in;
      rhi_ff      <= rhi_in;
      clo_ff      <= clo_in;
      chi_ff      <= chi_in;
      scan_col_ff <= scan_col_in;
      v_ff        <= v_in;
      greater_ff  <= greater_in;
      kept_ff     <= kept_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_CENTER) begin
         lft_ff  <= lft_in;
         rgt_ff  <= rgt_in;
         mask_ff <= mask_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_kept_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_key_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // row slot counters stay below the window size; the burst slot only once loaded
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (int'(slot_ff) < WINDOW) && ((state_ff == ST_IDLE) || (int'(rslot_ff) < WINDOW)))
      else $error("row slot out of range");

   // the last result of a burst returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && emit_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last result");

   // the result position stays inside the burst bounds
   a_burst_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (r_ff <= rhi_ff && c_ff >= clo_ff && c_ff <= chi_ff))
      else $error("result position outside burst");

   // scan reads stay within the clipped window columns
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_col_ff >= lft_ff && scan_col_ff <= rgt_ff))
      else $error("scan column outside window");
`endif

endmodule

[tb/window_local_max_suppression_unit_tb.sv]
// Testbench for window_local_max_suppression_unit: directed corner frames, then random
// frames with mid-frame size and threshold changes, checked against an in-bench predictor.
// Depends on wlms_pkg and the unit's RTL only.
module window_local_max_suppression_unit_tb;
   import wlms_pkg::*;

   localparam int WIN            = 11;
   localparam int HALF           = (WIN - 1) / 2;
   localparam int MAXW           = 2048;
   localparam int RANDOM_PIXELS  = 480;
   // quiet time before a register write or the end; covers pixels that emit nothing
   localparam int SETTLE_CYCLES  = 2 * WIN + 10;
   // cycles with no handshake on any channel before the run is declared hung
   localparam int WATCHDOG_LIMIT = 3000;
   // index with no register behind it; the block must ignore writes to it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {PACE_RX_STALLY, PACE_TX_GAPPY, PACE_FULL} pace_type;

   typedef struct {
      logic [ROW_W-1:0]      row;
      logic [PIX_COL_W-1:0]  col;
      logic [STRENGTH_W-1:0] value;
      logic                  keypoint;
      logic                  tail;
   } peak_result_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } reg_write_type;

   // Predicts the suppressed pixel stream and holds the results still awaited.
   class peak_scoreboard;
      bit [STRENGTH_W-1:0] line_rows [WIN*MAXW];
      int                  row_at;
      int                  col_at;
      bit [STRENGTH_W-1:0] threshold;
      bit [FW_W-1:0]       width_reg;
      bit [FH_W-1:0]       height_reg;
      peak_result_type     awaited[$];
      int                  mismatches;
      int                  pixels_in;
      int                  results_out;
      int                  reg_writes;

      function new();
         threshold  = THRESHOLD_RST;
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
      endfunction

      function int clip_width(bit [FW_W-1:0] raw);
         if (raw == 0) return 1;
         return (raw > MAXW) ? MAXW : int'(raw);
      endfunction

      function int clip_height(bit [FH_W-1:0] raw);
         if (raw == 0) return 1;
         return (raw > MAX_ROWS) ? int'(MAX_ROWS) : int'(raw);
      endfunction

      function bit [STRENGTH_W-1:0] stored(int r, int c);
         return line_rows[(r % WIN) * MAXW + c];
      endfunction

      // value kept for pixel (r,c): zeroed above threshold if a neighbor is strictly greater
      function bit [STRENGTH_W-1:0] kept_at(int r, int c, int w, int h);
         bit [STRENGTH_W-1:0] v;
         int top, bot, lft, rgt, m, n;
         v = stored(r, c);
         if (v <= threshold) return v;
         top = (r - HALF < 0) ? 0 : r - HALF;
         bot = (r + HALF > h - 1) ? h - 1 : r + HALF;
         lft = (c - HALF < 0) ? 0 : c - HALF;
         rgt = (c + HALF > w - 1) ? w - 1 : c + HALF;
         for (m = top; m <= bot; m++)
            for (n = lft; n <= rgt; n++)
               if (stored(m, n) > v) return '0;
         return v;
      endfunction

      function void take_pixel(bit [STRENGTH_W-1:0] strength);
         int w, h, row, col, rlo, rhi, clo, chi, r, c;
         peak_result_type e;
         w = clip_width(width_reg);
         h = clip_height(height_reg);
         if (row_at >= h || col_at >= w) begin
            row_at = 0;
            col_at = 0;
         end
         row = row_at;
         col = col_at;
         line_rows[(row % WIN) * MAXW + col] = strength;
         // last row flushes every pending row, last column every pending column
         rlo = row - HALF;
         rhi = (row == h - 1) ? row : rlo;
         if (rlo < 0) rlo = 0;
         clo = col - HALF;
         chi = (col == w - 1) ? col : clo;
         if (clo < 0) clo = 0;
         for (r = rlo; r <= rhi; r++) begin
            for (c = clo; c <= chi; c++) begin
               e.row      = r[ROW_W-1:0];
               e.col      = c[PIX_COL_W-1:0];
               e.value    = kept_at(r, c, w, h);
               e.keypoint = (e.value > threshold);
               e.tail     = (r == rhi && c == chi);
               awaited.insert(awaited.size(), e);
            end
         end
         if (col == w - 1) begin
            col_at = 0;
            row_at = (row == h - 1) ? 0 : row + 1;
         end else begin
            col_at = col + 1;
         end
         pixels_in++;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_THRESHOLD:    threshold  = data;
            CSR_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
            default: ;
         endcase
         reg_writes++;
      endfunction

      function void compare_field(string what, peak_result_type e,
                                  logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: pixel (%0d,%0d) %s expected 0x%0h actual 0x%0h",
                     $time, e.row, e.col, what, want, got);
         end
      endfunction

      function void check_result(logic [ROW_W-1:0] row, logic [PIX_COL_W-1:0] col,
                                 logic [STRENGTH_W-1:0] value, logic pad,
                                 logic keypoint, logic tail);
         peak_result_type e;
         results_out++;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: result with none awaited: row %0d col %0d value 0x%0h",
                     $time, row, col, value);
            return;
         end
         e = awaited.pop_front();
         compare_field("pixel_row", e, 32'(e.row), 32'(row));
         compare_field("pixel_col", e, 32'(e.col), 32'(col));
         compare_field("kept_value", e, 32'(e.value), 32'(value));
         compare_field("tdata pad", e, 32'(0), 32'(pad));
         compare_field("is_keypoint", e, 32'(e.keypoint), 32'(keypoint));
         compare_field("tlast", e, 32'(e.tail), 32'(tail));
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [STRENGTH_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   pace_type               pace = PACE_RX_STALLY;
   peak_scoreboard         sb;
   reg_write_type          reg_plan[$];
   int                     idle_cycles = 0;

   window_local_max_suppression_unit #(
      .WINDOW    (WIN),
      .MAX_WIDTH (MAXW)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int tx_gap_pct();
      case (pace)
         PACE_RX_STALLY: return 38;
         PACE_TX_GAPPY:  return 66;
         default:        return 0;
      endcase
   endfunction

   function automatic int rx_stall_pct();
      case (pace)
         PACE_RX_STALLY: return 66;
         PACE_TX_GAPPY:  return 38;
         default:        return 0;
      endcase
   endfunction

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct());

   // monitor: inputs are noted before results so a same-edge pair stays in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.take_pixel(req_tdata);
         // tdata: [11:0] row, [22:12] col, [38:23] kept value, [39] pad
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[11:0], rsp_tdata[22:12], rsp_tdata[38:23],
                            rsp_tdata[39], rsp_tuser[0], rsp_tlast);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results still awaited",
                     $time, idle_cycles, sb.awaited.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // All driving tasks are entered and left just after a falling edge.
   task automatic push_pixel(input logic [STRENGTH_W-1:0] strength);
      while ($urandom_range(0, 99) < tx_gap_pct()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= strength;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void queue_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] value);
      reg_write_type w;
      w.index = index;
      w.data  = value;
      reg_plan.insert(reg_plan.size(), w);
   endfunction

   // back-to-back register writes; valid only drops after the last one
   task automatic flush_regs();
      reg_write_type w;
      while (reg_plan.size() != 0) begin
         w = reg_plan.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_data  <= w.data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // drain every awaited result, then give trailing pixels time to retire
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mix of extremes, threshold neighbors, full-range noise and near-tie plateaus
   function automatic logic [STRENGTH_W-1:0] pick_strength();
      logic [STRENGTH_W-1:0] thr;
      thr = sb.threshold;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return thr;
         3:       return thr + 1'b1;
         4, 5:    return 16'($urandom_range(0, 16'hFFFF));
         default: return 16'd1000 + 16'($urandom_range(0, 2));
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] thr, width_val, height_val;
      int fed, w, h, left, n, i;

      sb = new();
      fed = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 1x1 frames (zero sizes): full-scale threshold first, spare index ignored
      settle();
      queue_reg(CSR_THRESHOLD, 16'hFFFF);
      queue_reg(CSR_FRAME_WIDTH, 16'h0000);
      queue_reg(CSR_FRAME_HEIGHT, 16'h0000);
      queue_reg(CSR_SPARE, 16'hFFFF);
      flush_regs();
      push_pixel(16'hFFFF);
      push_pixel(16'h0000);
      // zero threshold: one keypoint, one value equal to threshold
      settle();
      queue_reg(CSR_THRESHOLD, 16'h0000);
      flush_regs();
      push_pixel(16'h0001);
      push_pixel(16'h0000);

      // all-ones size writes saturate to 2048 x 4096; a few pixels of row 0
      settle();
      queue_reg(CSR_FRAME_WIDTH, 16'hFFFF);
      queue_reg(CSR_FRAME_HEIGHT, 16'hFFFF);
      flush_regs();
      push_pixel(16'h8000);
      push_pixel(16'h7FFF);
      push_pixel(16'h00FF);
      push_pixel(16'hFF00);
      push_pixel(16'h5A5A);
      push_pixel(16'hA5A5);

      // shrink below the current column: frame restarts at 0,0
      // 3x3 with two equal peaks, both kept, the rest suppressed
      settle();
      queue_reg(CSR_FRAME_WIDTH, 16'd3);
      queue_reg(CSR_FRAME_HEIGHT, 16'd3);
      queue_reg(CSR_THRESHOLD, 16'd4);
      flush_regs();
      for (i = 0; i < 9; i++)
         push_pixel((i < 2) ? 16'd7 : 16'd5);

      // single column: sub-threshold pixel passes between two peaks
      settle();
      queue_reg(CSR_FRAME_WIDTH, 16'd1);
      flush_regs();
      push_pixel(16'hFFFF);
      push_pixel(16'd3);
      push_pixel(16'hFFFF);

      // random segments: new settings at idle, then a full frame or a broken one
      while (fed < RANDOM_PIXELS) begin
         pace = pace_type'((fed * 3) / RANDOM_PIXELS);
         settle();
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0:       thr = 16'h0000;
               1:       thr = 16'hFFFF;
               2:       thr = 16'($urandom_range(0, 16'hFFFF));
               default: thr = 16'($urandom_range(0, 2000));
            endcase
            queue_reg(CSR_THRESHOLD, thr);
         end
         if ($urandom_range(0, 9) < 7) begin
            width_val = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(17, 16'hFFFF))
                                                     : 16'($urandom_range(0, 14));
            // widening past row 0 would read line store columns never written this frame
            if (sb.row_at == 0 ||
                sb.clip_width(width_val[FW_W-1:0]) <= sb.clip_width(sb.width_reg))
               queue_reg(CSR_FRAME_WIDTH, width_val);
         end
         if ($urandom_range(0, 9) < 6) begin
            height_val = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(13, 16'hFFFF))
                                                      : 16'($urandom_range(0, 12));
            queue_reg(CSR_FRAME_HEIGHT, height_val);
         end
         if ($urandom_range(0, 19) == 0)
            queue_reg(CSR_SPARE, 16'($urandom));
         flush_regs();

         // pixels left in the frame; a position outside the new size restarts it
         w = sb.clip_width(sb.width_reg);
         h = sb.clip_height(sb.height_reg);
         if (sb.row_at >= h || sb.col_at >= w)
            left = w * h;
         else
            left = w * h - (sb.row_at * w + sb.col_at);
         if (left > 300)
            n = $urandom_range(1, 30);
         else if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, left);
         else
            n = left;
         // stop at the planned pixel count
         if (n > RANDOM_PIXELS - fed)
            n = RANDOM_PIXELS - fed;
         repeat (n) begin
            push_pixel(pick_strength());
            fed++;
         end
      end

      settle();
      $display("run covered %0d pixels in, %0d results checked, %0d register writes",
               sb.pixels_in, sb.results_out, sb.reg_writes);
      $display("frames from 1x1 to 14x12, saturated sizes, mid-frame shrinks, three pacings");
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/wlms_pkg.sv
hw/rtl/window_local_max_suppression_unit.sv
tb/window_local_max_suppression_unit_tb.sv
